// File: src/sbpf_pkg.sv
// ----------------------------------------------------------------------------
// sbpf_pkg
// shared types and constants of the servo bus packet framer
// ----------------------------------------------------------------------------
package sbpf_pkg;

    typedef enum logic [2:0] {
        MODE_ACCEL      = 3'd0,
        MODE_WHEEL      = 3'd1,
        MODE_SYNC_RAW   = 3'd2,
        MODE_SYNC_PCT   = 3'd3,
        MODE_SINGLE     = 3'd4,
        MODE_SYNC_POS   = 3'd5
    } mode_t;

    localparam int  LIMIT_W           = 15;
    localparam int  CFG_ADDR_W        = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_LIMIT   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SINGLE_LIMIT = 1'b1;
    localparam logic [LIMIT_W-1:0]    SYNC_LIMIT_RST   = 15'd7000;
    localparam logic [LIMIT_W-1:0]    SINGLE_LIMIT_RST = 15'd10000;

    localparam int  BODY_BYTES  = 15;
    localparam int  BODY_IDX_W  = 4;
    localparam int  LEN_W       = 5;

    localparam logic [7:0] BYTE_HDR       = 8'hFF;
    localparam logic [7:0] BYTE_BCAST     = 8'hFE;
    localparam logic [7:0] INST_WRITE     = 8'h03;
    localparam logic [7:0] INST_SYNC      = 8'h83;
    localparam logic [7:0] ADDR_ACCEL     = 8'h29;
    localparam logic [7:0] ADDR_WHEEL     = 8'h21;
    localparam logic [7:0] ADDR_SPEED     = 8'h2E;
    localparam logic [7:0] ADDR_PCT_SPEED = 8'h20;
    localparam logic [7:0] ADDR_GOAL      = 8'h1E;

    localparam logic [LEN_W-1:0] LEN_SET    = 5'd8;
    localparam logic [LEN_W-1:0] LEN_SYNC   = 5'd14;
    localparam logic [LEN_W-1:0] LEN_SINGLE = 5'd9;
    localparam logic [LEN_W-1:0] LEN_POS    = 5'd18;

    // scaling by 1023/10000 and 1023/30000 as reciprocal multiply and shift
    localparam int          SCALE_W   = 26;
    localparam logic [SCALE_W-1:0] PCT_SCALE = 26'd13730474;
    localparam logic [SCALE_W-1:0] DEG_SCALE = 26'd36614597;
    localparam int          PCT_SHIFT = 27;
    localparam int          DEG_SHIFT = 30;
    localparam int          RAW_W     = 10;
    localparam int          PROD_W    = LIMIT_W + SCALE_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [LEN_W-1:0]               len;
        logic                           port;
        logic [BODY_BYTES-1:0][7:0]     body;
    } frame_t;

endpackage

// File: src/sbpf_front.sv
// ----------------------------------------------------------------------------
// sbpf_front
// command intake: clamps and scales the values and builds the packet body
// ----------------------------------------------------------------------------
module sbpf_front
    import sbpf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [LIMIT_W-1:0]     cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [2:0]             s_mode,
    input  logic [7:0]             s_id_a,
    input  logic signed [15:0]     s_value_a,
    input  logic [7:0]             s_id_b,
    input  logic signed [15:0]     s_value_b,
    input  logic signed [15:0]     s_servo_speed,
    input  logic                   q_full,
    output logic                   q_push,
    output frame_t                 q_frame
);

    logic [LIMIT_W-1:0] sync_limit_reg;
    logic [LIMIT_W-1:0] single_limit_reg;

    logic               s1_valid_reg;
    mode_t              s1_mode_reg;
    logic [7:0]         s1_id_a_reg;
    logic [7:0]         s1_id_b_reg;
    logic [7:0]         s1_accel_reg;
    logic [LIMIT_W-1:0] s1_mag0_reg;
    logic [LIMIT_W-1:0] s1_mag1_reg;
    logic [13:0]        s1_mags_reg;
    logic               s1_neg0_reg;
    logic               s1_neg1_reg;
    logic               s1_sp_pos_reg;

    logic               s2_valid_reg;
    mode_t              s2_mode_reg;
    logic [7:0]         s2_id_a_reg;
    logic [7:0]         s2_id_b_reg;
    logic [7:0]         s2_accel_reg;
    logic [LIMIT_W-1:0] s2_mag0_reg;
    logic [LIMIT_W-1:0] s2_mag1_reg;
    logic [PROD_W-1:0]  s2_prod0_reg;
    logic [PROD_W-1:0]  s2_prod1_reg;
    logic [PROD_W-1:0]  s2_prods_reg;
    logic               s2_neg0_reg;
    logic               s2_neg1_reg;
    logic               s2_sp_pos_reg;

    logic               adv1;
    logic               adv2;
    logic               mode_ok;
    mode_t              in_mode;
    logic [15:0]        abs_a;
    logic [15:0]        abs_b;
    logic [LIMIT_W-1:0] mag0_next;
    logic [LIMIT_W-1:0] mag1_next;
    logic [13:0]        mags_next;
    logic [SCALE_W-1:0] scale;
    logic [RAW_W-1:0]   q0;
    logic [RAW_W-1:0]   q1;
    logic [RAW_W-1:0]   rs_raw;
    logic [RAW_W-1:0]   rs;
    logic [15:0]        r0;
    logic [15:0]        r1;

    function automatic logic [LIMIT_W-1:0] clamp_mag(input logic [15:0] mag,
                                                     input logic [LIMIT_W-1:0] lim);
        clamp_mag = (mag > {1'b0, lim}) ? lim : mag[LIMIT_W-1:0];
    endfunction

    function automatic logic [LIMIT_W-1:0] clamp_deg(input logic signed [15:0] v);
        logic [LIMIT_W-1:0] res;
        if (v[15]) begin
            res = '0;
        end else if (v > 16'sd30000) begin
            res = 15'd30000;
        end else begin
            res = v[LIMIT_W-1:0];
        end
        clamp_deg = res;
    endfunction

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_limit_reg   <= SYNC_LIMIT_RST;
            single_limit_reg <= SINGLE_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SYNC_LIMIT:   sync_limit_reg   <= cfg_wdata;
                CFG_SINGLE_LIMIT: single_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign adv2    = !s2_valid_reg || !q_full;
    assign adv1    = !s1_valid_reg || adv2;
    assign s_ready = adv1;
    assign q_push  = s2_valid_reg && !q_full;
    assign mode_ok = (s_mode <= MODE_SYNC_POS);
    assign in_mode = mode_t'(s_mode);

    // stage 1: magnitudes and clamps
    always_comb begin
        abs_a     = s_value_a[15] ? (~s_value_a + 16'd1) : s_value_a;
        abs_b     = s_value_b[15] ? (~s_value_b + 16'd1) : s_value_b;
        mag0_next = '0;
        mag1_next = '0;
        unique case (in_mode)
            MODE_SYNC_RAW: begin
                mag0_next = clamp_mag(abs_a, sync_limit_reg);
                mag1_next = clamp_mag(abs_b, sync_limit_reg);
            end
            MODE_SYNC_PCT: begin
                mag0_next = clamp_mag(abs_a, 15'd10000);
                mag1_next = clamp_mag(abs_b, 15'd10000);
            end
            MODE_SINGLE: begin
                mag0_next = clamp_mag(abs_a, single_limit_reg);
            end
            MODE_SYNC_POS: begin
                mag0_next = clamp_deg(s_value_a);
                mag1_next = clamp_deg(s_value_b);
            end
            default: ;
        endcase
        if (s_servo_speed[15]) begin
            mags_next = '0;
        end else if (s_servo_speed > 16'sd10000) begin
            mags_next = 14'd10000;
        end else begin
            mags_next = s_servo_speed[13:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (adv2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv1) begin
                s1_valid_reg <= s_valid && mode_ok;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s1_mode_reg   <= in_mode;
            s1_id_a_reg   <= s_id_a;
            s1_id_b_reg   <= s_id_b;
            s1_accel_reg  <= s_value_a[7:0];
            s1_mag0_reg   <= mag0_next;
            s1_mag1_reg   <= mag1_next;
            s1_mags_reg   <= mags_next;
            s1_neg0_reg   <= s_value_a[15];
            s1_neg1_reg   <= s_value_b[15];
            s1_sp_pos_reg <= !s_servo_speed[15] && (s_servo_speed != 16'sd0);
        end
    end

    // stage 2: scaling products
    assign scale = (s1_mode_reg == MODE_SYNC_POS) ? DEG_SCALE : PCT_SCALE;

    always_ff @(posedge aclk) begin
        if (adv2) begin
            s2_mode_reg   <= s1_mode_reg;
            s2_id_a_reg   <= s1_id_a_reg;
            s2_id_b_reg   <= s1_id_b_reg;
            s2_accel_reg  <= s1_accel_reg;
            s2_mag0_reg   <= s1_mag0_reg;
            s2_mag1_reg   <= s1_mag1_reg;
            s2_prod0_reg  <= PROD_W'(s1_mag0_reg) * PROD_W'(scale);
            s2_prod1_reg  <= PROD_W'(s1_mag1_reg) * PROD_W'(scale);
            s2_prods_reg  <= PROD_W'(s1_mags_reg) * PROD_W'(PCT_SCALE);
            s2_neg0_reg   <= s1_neg0_reg;
            s2_neg1_reg   <= s1_neg1_reg;
            s2_sp_pos_reg <= s1_sp_pos_reg;
        end
    end

    // packet body
    always_comb begin
        if (s2_mode_reg == MODE_SYNC_POS) begin
            q0 = s2_prod0_reg[DEG_SHIFT +: RAW_W];
            q1 = s2_prod1_reg[DEG_SHIFT +: RAW_W];
        end else begin
            q0 = s2_prod0_reg[PCT_SHIFT +: RAW_W];
            q1 = s2_prod1_reg[PCT_SHIFT +: RAW_W];
        end
        rs_raw = s2_prods_reg[PCT_SHIFT +: RAW_W];
        rs     = (rs_raw == '0 && s2_sp_pos_reg) ? RAW_W'(1) : rs_raw;

        unique case (s2_mode_reg)
            MODE_SYNC_PCT: begin
                r0 = {5'd0, s2_neg0_reg, q0};
                r1 = {5'd0, s2_neg1_reg, q1};
            end
            MODE_SYNC_POS: begin
                r0 = {6'd0, q0};
                r1 = {6'd0, q1};
            end
            default: begin
                r0 = {s2_neg0_reg, s2_mag0_reg};
                r1 = {s2_neg1_reg, s2_mag1_reg};
            end
        endcase

        q_frame      = '0;
        q_frame.port = (s2_mode_reg == MODE_SYNC_PCT) || (s2_mode_reg == MODE_SYNC_POS);
        unique case (s2_mode_reg)
            MODE_ACCEL, MODE_WHEEL: begin
                q_frame.len     = LEN_SET;
                q_frame.body[0] = s2_id_a_reg;
                q_frame.body[1] = 8'h04;
                q_frame.body[2] = INST_WRITE;
                q_frame.body[3] = (s2_mode_reg == MODE_ACCEL) ? ADDR_ACCEL : ADDR_WHEEL;
                q_frame.body[4] = (s2_mode_reg == MODE_ACCEL) ? s2_accel_reg : 8'h01;
            end
            MODE_SYNC_RAW, MODE_SYNC_PCT: begin
                q_frame.len      = LEN_SYNC;
                q_frame.body[0]  = BYTE_BCAST;
                q_frame.body[1]  = 8'h0A;
                q_frame.body[2]  = INST_SYNC;
                q_frame.body[3]  = (s2_mode_reg == MODE_SYNC_RAW) ? ADDR_SPEED : ADDR_PCT_SPEED;
                q_frame.body[4]  = 8'h02;
                q_frame.body[5]  = s2_id_a_reg;
                q_frame.body[6]  = r0[7:0];
                q_frame.body[7]  = r0[15:8];
                q_frame.body[8]  = s2_id_b_reg;
                q_frame.body[9]  = r1[7:0];
                q_frame.body[10] = r1[15:8];
            end
            MODE_SINGLE: begin
                q_frame.len     = LEN_SINGLE;
                q_frame.body[0] = s2_id_a_reg;
                q_frame.body[1] = 8'h05;
                q_frame.body[2] = INST_WRITE;
                q_frame.body[3] = ADDR_SPEED;
                q_frame.body[4] = r0[7:0];
                q_frame.body[5] = r0[15:8];
            end
            MODE_SYNC_POS: begin
                q_frame.len      = LEN_POS;
                q_frame.body[0]  = BYTE_BCAST;
                q_frame.body[1]  = 8'h0E;
                q_frame.body[2]  = INST_SYNC;
                q_frame.body[3]  = ADDR_GOAL;
                q_frame.body[4]  = 8'h04;
                q_frame.body[5]  = s2_id_a_reg;
                q_frame.body[6]  = r0[7:0];
                q_frame.body[7]  = r0[15:8];
                q_frame.body[8]  = rs[7:0];
                q_frame.body[9]  = {6'd0, rs[9:8]};
                q_frame.body[10] = s2_id_b_reg;
                q_frame.body[11] = r1[7:0];
                q_frame.body[12] = r1[15:8];
                q_frame.body[13] = rs[7:0];
                q_frame.body[14] = {6'd0, rs[9:8]};
            end
            default: ;
        endcase
    end

endmodule

// File: src/sbpf_fifo.sv
// ----------------------------------------------------------------------------
// sbpf_fifo
// short request queue between packet builder and byte serializer
// ----------------------------------------------------------------------------
module sbpf_fifo
    import sbpf_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  frame_t push_frame,
    output logic   full,
    input  logic   pop,
    output frame_t head,
    output logic   empty
);

    frame_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

// File: src/sbpf_back.sv
// ----------------------------------------------------------------------------
// sbpf_back
// byte serializer: header, body bytes and running checksum
// ----------------------------------------------------------------------------
module sbpf_back
    import sbpf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  frame_t     head,
    input  logic       empty,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_tx_byte,
    output logic       m_port,
    output logic       m_last
);

    logic [LEN_W-1:0]      idx_reg;
    logic [LEN_W-1:0]      idx_next;
    logic [7:0]            sum_reg;
    logic [7:0]            sum_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [7:0]            m_tx_byte_reg;
    logic                  m_port_reg;
    logic                  m_last_reg;
    logic                  load;
    logic                  emit;
    logic                  is_last;
    logic [BODY_IDX_W-1:0] body_idx;
    logic [LEN_W-1:0]      body_pos;
    logic [7:0]            cur_byte;

    assign load     = !m_valid_reg || m_ready;
    assign emit     = load && !empty;
    assign is_last  = (idx_reg == head.len - 1'b1);
    assign body_pos = idx_reg - LEN_W'(2);
    assign body_idx = body_pos[BODY_IDX_W-1:0];
    assign pop      = emit && is_last;

    always_comb begin
        sum_next     = sum_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (idx_reg < LEN_W'(2)) begin
            cur_byte = BYTE_HDR;
        end else if (is_last) begin
            cur_byte = ~sum_reg;
        end else begin
            cur_byte = head.body[body_idx];
        end
        if (load) begin
            m_valid_next = !empty;
        end
        if (emit) begin
            if (is_last) begin
                idx_next = '0;
                sum_next = '0;
            end else begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg >= LEN_W'(2)) begin
                    sum_next = sum_reg + cur_byte;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tx_byte_reg <= cur_byte;
            m_port_reg    <= head.port;
            m_last_reg    <= is_last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_tx_byte = m_tx_byte_reg;
    assign m_port    = m_port_reg;
    assign m_last    = m_last_reg;

endmodule

// File: src/servo_bus_packet_framer.sv
// ----------------------------------------------------------------------------
// servo_bus_packet_framer
// turns servo commands into framed instruction packets, one byte per result
// ----------------------------------------------------------------------------
// usage:
//   s_* channel takes one command per request (mode, ids, values, speed);
//   m_* channel returns the packet bytes, m_port selects the serial bus and
//   m_last marks the checksum byte that ends the packet
//   modes 6 and 7 are accepted and dropped without output
//   cfg_wr_en/cfg_addr/cfg_wdata write one speed limit, selected by cfg_addr
// path: a command passes both intake stages, the queue and the output register
// throughput: one byte per cycle on m_* while m_ready is high; a packet is 8, 9,
//   14 or 18 bytes depending on mode; the byte serializer sets this figure
//   commands are taken every cycle until the two intake stages and the
//   four-entry queue are full
// reset: clears the pipeline, queue and output valid; limits go to 7000
//   and 10000
// stall: while m_ready is low the current byte holds and the queue absorbs
//   new commands, then s_ready drops
// ----------------------------------------------------------------------------
module servo_bus_packet_framer
    import sbpf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [LIMIT_W-1:0]     cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [2:0]             s_mode,
    input  logic [7:0]             s_id_a,
    input  logic signed [15:0]     s_value_a,
    input  logic [7:0]             s_id_b,
    input  logic signed [15:0]     s_value_b,
    input  logic signed [15:0]     s_servo_speed,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_tx_byte,
    output logic                   m_port,
    output logic                   m_last
);

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;
    frame_t q_in;
    frame_t q_head;

    sbpf_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_id_a        (s_id_a),
        .s_value_a     (s_value_a),
        .s_id_b        (s_id_b),
        .s_value_b     (s_value_b),
        .s_servo_speed (s_servo_speed),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_frame       (q_in)
    );

    sbpf_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_frame (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    sbpf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_tx_byte (m_tx_byte),
        .m_port    (m_port),
        .m_last    (m_last)
    );

endmodule

// File: src/sbpf_checker.sv
// ----------------------------------------------------------------------------
// sbpf_checker
// port-level checks of the servo bus packet framer
// ----------------------------------------------------------------------------
module sbpf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_tx_byte,
    input logic       m_port,
    input logic       m_last
);

    // no output right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // intake pipeline keeps output quiet right after reset release
    a_reset_latency: assert property (@(posedge aclk)
        !aresetn ##1 aresetn |=> !m_valid)
        else $error("output too early after reset");

    // stalled byte holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte)
                                && $stable(m_port) && $stable(m_last))
        else $error("stalled byte changed");

    // a packet that follows directly opens with the header
    a_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid || (m_tx_byte == 8'hFF && !m_last))
        else $error("packet does not open with header");

endmodule

bind servo_bus_packet_framer sbpf_checker u_checker (.*);

// File: sim/servo_bus_packet_framer_test.sv
// ----------------------------------------------------------------------------
// servo_bus_packet_framer_test
// self-checking bench for the servo bus packet framer: every command request
// is framed by a behavioral model and each packet byte, bus select and
// end-of-packet flag is compared in order; directed cases cover speed clamps,
// percent and degree scaling and dropped modes, then random traffic runs
// under changing speed limits and handshake pressure
// ----------------------------------------------------------------------------
module servo_bus_packet_framer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sbpf_pkg::*;

    localparam logic [2:0] MODE_RESERVED_LO = 3'd6;
    localparam logic [2:0] MODE_RESERVED_HI = 3'd7;

    localparam logic [7:0] PKT_HEADER       = 8'hFF;
    localparam logic [7:0] PKT_BROADCAST    = 8'hFE;
    localparam logic [7:0] PKT_WRITE        = 8'h03;
    localparam logic [7:0] PKT_SYNC_WRITE   = 8'h83;
    localparam logic [7:0] PKT_REG_ACCEL    = 8'h29;
    localparam logic [7:0] PKT_REG_WHEEL    = 8'h21;
    localparam logic [7:0] PKT_REG_SPEED    = 8'h2E;
    localparam logic [7:0] PKT_REG_PCT      = 8'h20;
    localparam logic [7:0] PKT_REG_GOAL     = 8'h1E;
    localparam logic [7:0] PKT_LEN_SET      = 8'h04;
    localparam logic [7:0] PKT_LEN_SINGLE   = 8'h05;
    localparam logic [7:0] PKT_LEN_SYNC     = 8'h0A;
    localparam logic [7:0] PKT_LEN_POS      = 8'h0E;
    localparam logic [7:0] PKT_WHEEL_ON     = 8'h01;
    localparam logic [7:0] PKT_SPEED_WIDTH  = 8'h02;
    localparam logic [7:0] PKT_POS_WIDTH    = 8'h04;

    localparam int PCT_FULL = 10000;
    localparam int DEG_FULL = 30000;
    localparam int RAW_FULL = 1023;

    localparam logic [LIMIT_W-1:0] SYNC_LIMIT_DEFAULT   = 15'd7000;
    localparam logic [LIMIT_W-1:0] SINGLE_LIMIT_DEFAULT = 15'd10000;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX            = 15'h7FFF;

    localparam int HOLD_OFF_CYCLES = 32;
    localparam int PHASE_COMMANDS  = 134;

    typedef struct packed {
        logic [2:0]         mode;
        logic [7:0]         id_a;
        logic signed [15:0] value_a;
        logic [7:0]         id_b;
        logic signed [15:0] value_b;
        logic signed [15:0] servo_speed;
    } servo_cmd_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       port;
        logic       last;
    } bus_byte_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [LIMIT_W-1:0]     cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [2:0]             s_mode;
    logic [7:0]             s_id_a;
    logic signed [15:0]     s_value_a;
    logic [7:0]             s_id_b;
    logic signed [15:0]     s_value_b;
    logic signed [15:0]     s_servo_speed;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [7:0]             m_tx_byte;
    logic                   m_port;
    logic                   m_last;

    bus_byte_t          packet_bytes_due[$];
    logic [LIMIT_W-1:0] sync_limit_shadow;
    logic [LIMIT_W-1:0] single_limit_shadow;
    int                 error_count = 0;
    int unsigned        send_idle_pct = 13;
    int unsigned        recv_stall_pct = 86;

    servo_bus_packet_framer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_id_a        (s_id_a),
        .s_value_a     (s_value_a),
        .s_id_b        (s_id_b),
        .s_value_b     (s_value_b),
        .s_servo_speed (s_servo_speed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tx_byte     (m_tx_byte),
        .m_port        (m_port),
        .m_last        (m_last)
    );

    always #4 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [15:0] clamp_sign_mag(logic signed [15:0] v,
                                                   logic [LIMIT_W-1:0] limit);
        int mag;
        mag = (v < 0) ? -int'(v) : int'(v);
        if (mag > int'(limit)) mag = int'(limit);
        return (v < 0) ? (16'(mag) | 16'h8000) : 16'(mag);
    endfunction

    function automatic logic [15:0] percent_to_raw(logic signed [15:0] v);
        int mag;
        mag = (v < 0) ? -int'(v) : int'(v);
        if (mag > PCT_FULL) mag = PCT_FULL;
        mag = mag * RAW_FULL / PCT_FULL;
        return (v < 0) ? (16'(mag) | 16'h0400) : 16'(mag);
    endfunction

    function automatic logic [15:0] degree_to_raw(logic signed [15:0] v);
        int deg;
        deg = int'(v);
        if (deg < 0) deg = 0;
        if (deg > DEG_FULL) deg = DEG_FULL;
        return 16'(deg * RAW_FULL / DEG_FULL);
    endfunction

    function automatic logic [15:0] move_speed_to_raw(logic signed [15:0] v);
        int spd;
        int raw;
        spd = int'(v);
        if (spd < 0) spd = 0;
        if (spd > PCT_FULL) spd = PCT_FULL;
        raw = spd * RAW_FULL / PCT_FULL;
        if (raw == 0 && spd > 0) raw = 1;
        return 16'(raw);
    endfunction

    // appends the expected packet bytes of one accepted command
    function automatic void frame_command(servo_cmd_t cmd);
        logic [7:0]  body[$];
        logic [15:0] raw_a;
        logic [15:0] raw_b;
        logic [15:0] move_raw;
        logic [7:0]  sum;
        logic        second_bus;
        second_bus = 1'b0;
        case (cmd.mode)
            MODE_ACCEL: begin
                body = '{cmd.id_a, PKT_LEN_SET, PKT_WRITE, PKT_REG_ACCEL, cmd.value_a[7:0]};
            end
            MODE_WHEEL: begin
                body = '{cmd.id_a, PKT_LEN_SET, PKT_WRITE, PKT_REG_WHEEL, PKT_WHEEL_ON};
            end
            MODE_SYNC_RAW: begin
                raw_a = clamp_sign_mag(cmd.value_a, sync_limit_shadow);
                raw_b = clamp_sign_mag(cmd.value_b, sync_limit_shadow);
                body = '{PKT_BROADCAST, PKT_LEN_SYNC, PKT_SYNC_WRITE, PKT_REG_SPEED,
                         PKT_SPEED_WIDTH, cmd.id_a, raw_a[7:0], raw_a[15:8],
                         cmd.id_b, raw_b[7:0], raw_b[15:8]};
            end
            MODE_SYNC_PCT: begin
                raw_a = percent_to_raw(cmd.value_a);
                raw_b = percent_to_raw(cmd.value_b);
                second_bus = 1'b1;
                body = '{PKT_BROADCAST, PKT_LEN_SYNC, PKT_SYNC_WRITE, PKT_REG_PCT,
                         PKT_SPEED_WIDTH, cmd.id_a, raw_a[7:0], raw_a[15:8],
                         cmd.id_b, raw_b[7:0], raw_b[15:8]};
            end
            MODE_SINGLE: begin
                raw_a = clamp_sign_mag(cmd.value_a, single_limit_shadow);
                body = '{cmd.id_a, PKT_LEN_SINGLE, PKT_WRITE, PKT_REG_SPEED,
                         raw_a[7:0], raw_a[15:8]};
            end
            MODE_SYNC_POS: begin
                raw_a = degree_to_raw(cmd.value_a);
                raw_b = degree_to_raw(cmd.value_b);
                move_raw = move_speed_to_raw(cmd.servo_speed);
                second_bus = 1'b1;
                body = '{PKT_BROADCAST, PKT_LEN_POS, PKT_SYNC_WRITE, PKT_REG_GOAL,
                         PKT_POS_WIDTH, cmd.id_a, raw_a[7:0], raw_a[15:8],
                         move_raw[7:0], move_raw[15:8], cmd.id_b, raw_b[7:0],
                         raw_b[15:8], move_raw[7:0], move_raw[15:8]};
            end
            default: begin
                return;
            end
        endcase
        sum = 8'h00;
        foreach (body[i]) sum += body[i];
        packet_bytes_due.push_back('{PKT_HEADER, second_bus, 1'b0});
        packet_bytes_due.push_back('{PKT_HEADER, second_bus, 1'b0});
        foreach (body[i]) packet_bytes_due.push_back('{body[i], second_bus, 1'b0});
        packet_bytes_due.push_back('{~sum, second_bus, 1'b1});
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        error_count++;
    endtask

    always @(posedge aclk) begin
        bus_byte_t due;
        if (aresetn && m_valid && m_ready) begin
            if (packet_bytes_due.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %h", m_tx_byte));
            end else begin
                due = packet_bytes_due.pop_front();
                if (m_tx_byte !== due.tx_byte)
                    report_mismatch($sformatf("tx_byte %h, want %h", m_tx_byte, due.tx_byte));
                if (m_port !== due.port)
                    report_mismatch($sformatf("port %b, want %b", m_port, due.port));
                if (m_last !== due.last)
                    report_mismatch($sformatf("last %b, want %b", m_last, due.last));
            end
        end
    end

    task automatic send_command(servo_cmd_t cmd);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_mode        = cmd.mode;
        s_id_a        = cmd.id_a;
        s_value_a     = cmd.value_a;
        s_id_b        = cmd.id_b;
        s_value_b     = cmd.value_b;
        s_servo_speed = cmd.servo_speed;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        frame_command(cmd);
    endtask

    task automatic wait_until_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (packet_bytes_due.size() != 0) @(negedge aclk);
        repeat (HOLD_OFF_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limits(logic [LIMIT_W-1:0] sync_value,
                                logic [LIMIT_W-1:0] single_value);
        wait_until_drained();
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = CFG_SYNC_LIMIT;
        cfg_wdata = sync_value;
        @(negedge aclk);
        cfg_addr  = CFG_SINGLE_LIMIT;
        cfg_wdata = single_value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sync_limit_shadow   = sync_value;
        single_limit_shadow = single_value;
    endtask

    function automatic logic signed [15:0] random_value();
        case ($urandom_range(4))
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(24000)) - 12000);
            2: return 16'(int'($urandom_range(31000)) - 500);
            3: return 16'(int'($urandom_range(40)) - 20);
            default: begin
                case ($urandom_range(3))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
        endcase
    endfunction

    function automatic servo_cmd_t random_command();
        servo_cmd_t cmd;
        if ($urandom_range(99) < 4)
            cmd.mode = $urandom_range(1) ? MODE_RESERVED_HI : MODE_RESERVED_LO;
        else
            cmd.mode = 3'($urandom_range(5));
        cmd.id_a        = 8'($urandom);
        cmd.id_b        = 8'($urandom);
        cmd.value_a     = random_value();
        cmd.value_b     = random_value();
        cmd.servo_speed = random_value();
        return cmd;
    endfunction

    task automatic send_fields(logic [2:0] mode, logic [7:0] id_a, int value_a,
                               logic [7:0] id_b, int value_b, int servo_speed);
        send_command('{mode, id_a, 16'(value_a), id_b, 16'(value_b), 16'(servo_speed)});
    endtask

    task automatic test_reset_limits();
        send_fields(MODE_SYNC_RAW, 8'h00, 32767, 8'hFF, -32768, 0);
        send_fields(MODE_SYNC_RAW, 8'h5A, 7000, 8'hA5, -7001, 0);
        send_fields(MODE_SINGLE, 8'hFE, 10001, 8'h00, 0, 0);
        send_fields(MODE_SINGLE, 8'h01, -10000, 8'h00, 0, 0);
    endtask

    task automatic test_fixed_modes();
        send_fields(MODE_ACCEL, 8'h00, 0, 8'h00, 0, 0);
        send_fields(MODE_ACCEL, 8'hFF, -1, 8'hFF, -1, -1);
        send_fields(MODE_WHEEL, 8'hFE, 12345, 8'h33, 0, 0);
        send_fields(MODE_WHEEL, 8'hFF, -32768, 8'hFF, 32767, 32767);
    endtask

    task automatic test_scaling();
        send_fields(MODE_SYNC_PCT, 8'h01, 10000, 8'h02, -10000, 0);
        send_fields(MODE_SYNC_PCT, 8'h03, 10001, 8'h04, -32768, 0);
        send_fields(MODE_SYNC_PCT, 8'h05, 1, 8'h06, -1, 0);
        send_fields(MODE_SYNC_PCT, 8'h07, 0, 8'h08, 9, 0);
        send_fields(MODE_SYNC_PCT, 8'hFF, 32767, 8'h00, -9999, 0);
        send_fields(MODE_SYNC_POS, 8'h01, -1, 8'h02, 30001, 0);
        send_fields(MODE_SYNC_POS, 8'h03, 0, 8'h04, 30000, 1);
        send_fields(MODE_SYNC_POS, 8'h05, 29, 8'h06, 32767, 9);
        send_fields(MODE_SYNC_POS, 8'h07, 30000, 8'h08, 15000, 10000);
        send_fields(MODE_SYNC_POS, 8'hFF, -32768, 8'h00, 1, -1);
        send_fields(MODE_SYNC_POS, 8'h10, 100, 8'h20, 200, 32767);
    endtask

    task automatic test_dropped_modes();
        send_fields(MODE_RESERVED_LO, 8'h12, 1000, 8'h34, -1000, 500);
        send_fields(MODE_RESERVED_HI, 8'hFF, -1, 8'hFF, -1, -1);
        send_fields(MODE_WHEEL, 8'h42, 0, 8'h00, 0, 0);
    endtask

    task automatic test_speed_limits();
        logic [LIMIT_W-1:0] sync_values[4];
        logic [LIMIT_W-1:0] single_values[4];
        sync_values   = '{15'd0, LIMIT_MAX, 15'd1, 15'($urandom)};
        single_values = '{LIMIT_MAX, 15'd0, 15'($urandom), 15'd1};
        foreach (sync_values[k]) begin
            write_limits(sync_values[k], single_values[k]);
            send_fields(MODE_SYNC_RAW, 8'($urandom), 32767, 8'($urandom), -32768, 0);
            send_fields(MODE_SINGLE, 8'($urandom), -32768, 8'h00, 0, 0);
            send_fields(MODE_SINGLE, 8'($urandom), 32767, 8'h00, 0, 0);
            repeat (4) begin
                send_fields(MODE_SYNC_RAW, 8'($urandom), int'(random_value()),
                            8'($urandom), int'(random_value()), 0);
                send_fields(MODE_SINGLE, 8'($urandom), int'(random_value()),
                            8'($urandom), 0, 0);
            end
        end
    endtask

    task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
                                       bit hold_midway);
        servo_cmd_t cmd;
        int         sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if ($urandom_range(3) == 0)
            write_limits(15'($urandom_range(64)), 15'($urandom_range(64)));
        else
            write_limits(15'($urandom), 15'($urandom));
        sent = 0;
        while (sent < PHASE_COMMANDS) begin
            cmd = random_command();
            send_command(cmd);
            if (cmd.mode <= MODE_SYNC_POS) sent++;
            // let the queue run dry once with the sender held off
            if (hold_midway && sent == PHASE_COMMANDS / 2) begin
                wait_until_drained();
                hold_midway = 1'b0;
            end
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = CFG_SYNC_LIMIT;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_mode        = MODE_ACCEL;
        s_id_a        = '0;
        s_value_a     = '0;
        s_id_b        = '0;
        s_value_b     = '0;
        s_servo_speed = '0;
        sync_limit_shadow   = SYNC_LIMIT_DEFAULT;
        single_limit_shadow = SINGLE_LIMIT_DEFAULT;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_limits();
        test_fixed_modes();
        test_scaling();
        test_dropped_modes();
        test_speed_limits();
        test_random_traffic(13, 86, 1'b1);
        test_random_traffic(86, 13, 1'b0);
        test_random_traffic(0, 0, 1'b0);
        wait_until_drained();

        if (error_count == 0) begin
            $display("servo_bus_packet_framer regression: pass");
        end else begin
            $display("servo_bus_packet_framer regression: fail");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("servo_bus_packet_framer regression: fail");
        $finish;
    end

endmodule

// File: files.f
src/sbpf_pkg.sv
src/sbpf_front.sv
src/sbpf_fifo.sv
src/sbpf_back.sv
src/servo_bus_packet_framer.sv
src/sbpf_checker.sv
sim/servo_bus_packet_framer_test.sv
